FILE: hw/rtl/fwpa_pkg.sv
// fwpa_pkg: shared constants, types and the arctangent table for the
// farthest white pixel angle core; no dependencies
`default_nettype none

package fwpa_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W    = COL_W + 1;
  localparam int PIXEL_W    = 8;
  localparam int LEVEL_W    = 8;
  localparam int CENTER_W   = 12;
  localparam int COORD_W    = 12;
  localparam int SQ_W       = (COL_W > ROW_W) ? 2 * COL_W : 2 * ROW_W;
  localparam int DIST_W     = SQ_W + 1;

  // angle arithmetic
  localparam int ANGLE_FRAC    = 6;
  localparam int ANGLE_W       = 15;
  localparam int ZBITS         = 16;
  localparam int SCALE_SHIFT   = 10;
  localparam int CORDIC_STEPS  = 20;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int DATA_W        = 26;
  localparam int ROUND_SHIFT   = ZBITS - ANGLE_FRAC;
  localparam int ROUND_HALF    = 1 << (ROUND_SHIFT - 1);
  localparam int FULL_ANGLE    = 360 << ANGLE_FRAC;
  localparam int RIGHT_ANGLE   = 90 << ANGLE_FRAC;
  localparam int HALF_TURN_Z   = 180 << ZBITS;
  localparam int R_W           = DATA_W - ROUND_SHIFT + 1;

  // frame result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // register file
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST = WIDTH_W'(640);
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = CENTER_W'(416);
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = CENTER_W'(253);
  localparam logic [LEVEL_W-1:0]  WHITE_LEVEL_RST = LEVEL_W'(255);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_CENTER_X    = 2'd1,
    REG_CENTER_Y    = 2'd2,
    REG_WHITE_LEVEL = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [LEVEL_W-1:0]  white_level;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] far_x;
    logic [ROW_W-1:0] far_y;
    logic             found;
  } frame_res_t;

  // arctangent of 2^-i in units of 2^-16 degree
  function automatic logic [DATA_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [DATA_W-1:0] v;
    case (idx)
      5'd0:    v = DATA_W'(2949120);
      5'd1:    v = DATA_W'(1740967);
      5'd2:    v = DATA_W'(919879);
      5'd3:    v = DATA_W'(466945);
      5'd4:    v = DATA_W'(234379);
      5'd5:    v = DATA_W'(117304);
      5'd6:    v = DATA_W'(58666);
      5'd7:    v = DATA_W'(29335);
      5'd8:    v = DATA_W'(14668);
      5'd9:    v = DATA_W'(7334);
      5'd10:   v = DATA_W'(3667);
      5'd11:   v = DATA_W'(1833);
      5'd12:   v = DATA_W'(917);
      5'd13:   v = DATA_W'(458);
      5'd14:   v = DATA_W'(229);
      5'd15:   v = DATA_W'(115);
      5'd16:   v = DATA_W'(57);
      5'd17:   v = DATA_W'(29);
      5'd18:   v = DATA_W'(14);
      5'd19:   v = DATA_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fwpa_front.sv
// fwpa_front: pixel intake, raster counters, squared distance pipeline and
// farthest point tracking; depends on fwpa_pkg
`default_nettype none

module fwpa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fwpa_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fwpa_pkg::PIXEL_W-1:0]  pixel_i,
  input  logic                          end_of_frame_i,
  input  logic [fwpa_pkg::Q_CNT_W-1:0]  q_count_i,
  output logic                          push_o,
  output fwpa_pkg::frame_res_t          push_data_o
);
  import fwpa_pkg::*;

  logic                      accept;
  logic [WIDTH_W-1:0]        width_clamped;
  logic [WIDTH_W-1:0]        col_inc;
  logic                      col_wrap;
  logic [COL_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [Q_CNT_W-1:0]        in_flight;

  // stage a: offsets from center
  logic                      a_valid_q;
  logic                      a_hit_q, a_eof_q;
  logic signed [COL_W:0]     a_dx_q;
  logic signed [ROW_W:0]     a_dy_q;
  logic [COL_W-1:0]          a_col_q;
  logic [ROW_W-1:0]          a_row_q;

  // stage b: squares
  logic                      b_valid_q;
  logic                      b_hit_q, b_eof_q;
  logic [2*COL_W-1:0]        b_sq_x_q;
  logic [2*ROW_W-1:0]        b_sq_y_q;
  logic [COL_W-1:0]          b_col_q;
  logic [ROW_W-1:0]          b_row_q;
  logic signed [2*COL_W+1:0] prod_x;
  logic signed [2*ROW_W+1:0] prod_y;

  // stage c: best point
  logic [DIST_W-1:0]         dist_sum;
  logic                      upd;
  logic [DIST_W-1:0]         best_dist_q, best_dist_d;
  logic [COL_W-1:0]          best_x_q, best_x_d;
  logic [ROW_W-1:0]          best_y_q, best_y_d;

  // space check: every end of frame in flight must find a queue slot
  assign in_flight  = Q_CNT_W'(a_valid_q & a_eof_q) + Q_CNT_W'(b_valid_q & b_eof_q);
  assign in_ready_o = (q_count_i + in_flight) < Q_CNT_W'(Q_DEPTH);
  assign accept     = in_valid_i & in_ready_o;

  // width clamped to [1, MAX_WIDTH]
  always_comb begin
    if (cfg_i.image_width == '0) begin
      width_clamped = WIDTH_W'(1);
    end else if (cfg_i.image_width > WIDTH_W'(MAX_WIDTH)) begin
      width_clamped = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_clamped = cfg_i.image_width;
    end
  end

  // raster counters
  assign col_inc  = {1'b0, col_q} + WIDTH_W'(1);
  assign col_wrap = col_inc >= width_clamped;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_of_frame_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_wrap) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= accept;
      b_valid_q <= a_valid_q;
    end
  end

  // stage a and b payload
  assign prod_x = a_dx_q * a_dx_q;
  assign prod_y = a_dy_q * a_dy_q;

  always_ff @(posedge clk_i) begin
    a_hit_q  <= (pixel_i == cfg_i.white_level);
    a_eof_q  <= end_of_frame_i;
    a_dx_q   <= $signed({1'b0, col_q}) - $signed({1'b0, cfg_i.center_x});
    a_dy_q   <= $signed({1'b0, row_q}) - $signed({1'b0, cfg_i.center_y});
    a_col_q  <= col_q;
    a_row_q  <= row_q;
    b_hit_q  <= a_hit_q;
    b_eof_q  <= a_eof_q;
    b_sq_x_q <= prod_x[2*COL_W-1:0];
    b_sq_y_q <= prod_y[2*ROW_W-1:0];
    b_col_q  <= a_col_q;
    b_row_q  <= a_row_q;
  end

  // compare against the kept distance, strictly greater wins
  assign dist_sum = DIST_W'(b_sq_x_q) + DIST_W'(b_sq_y_q);
  assign upd      = b_valid_q & b_hit_q & (dist_sum > best_dist_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    if (upd) begin
      best_dist_d = dist_sum;
      best_x_d    = b_col_q;
      best_y_d    = b_row_q;
    end
  end

  // frame result goes to the queue, kept point clears
  assign push_o            = b_valid_q & b_eof_q;
  assign push_data_o.far_x = best_x_d;
  assign push_data_o.far_y = best_y_d;
  assign push_data_o.found = (best_dist_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
    end else if (push_o) begin
      best_dist_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
    end else begin
      best_dist_q <= best_dist_d;
      best_x_q    <= best_x_d;
      best_y_q    <= best_y_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fwpa_fifo.sv
// fwpa_fifo: short queue of per-frame results between front and back;
// depends on fwpa_pkg
`default_nettype none

module fwpa_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  fwpa_pkg::frame_res_t         data_i,
  input  logic                         pop_i,
  output fwpa_pkg::frame_res_t         data_o,
  output logic                         empty_o,
  output logic [fwpa_pkg::Q_CNT_W-1:0] count_o
);
  import fwpa_pkg::*;

  frame_res_t           entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   count_q;

  assign data_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      count_q <= count_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fwpa_cordic.sv
// fwpa_cordic: back end, iterative vectoring cordic giving the clock-hand
// angle of each queued frame result, with the output register; depends on fwpa_pkg
`default_nettype none

module fwpa_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fwpa_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  fwpa_pkg::frame_res_t          q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fwpa_pkg::COORD_W-1:0]  far_x_o,
  output logic [fwpa_pkg::COORD_W-1:0]  far_y_o,
  output logic [fwpa_pkg::ANGLE_W-1:0]  hand_angle_o,
  output logic                          found_o
);
  import fwpa_pkg::*;

  back_state_e              state_q, state_d;
  logic                     out_free;
  logic                     load_out;
  logic                     last_step;

  logic signed [ROW_W:0]    du_raw;
  logic signed [COL_W:0]    dv_raw;
  logic signed [DATA_W-1:0] du_ext, dv_ext;

  logic signed [DATA_W-1:0] du_q, dv_q, z_q;
  logic [STEP_W-1:0]        step_q;
  logic                     zero_q;
  frame_res_t               hold_q;

  logic signed [DATA_W-1:0] du_sh, dv_sh, atan_val;
  logic signed [DATA_W-1:0] z_rnd;
  logic signed [R_W-1:0]    r_val, ang_wrap;
  logic [ANGLE_W-1:0]       angle;

  logic                     out_valid_q;

  // vector from center, up is positive
  assign du_raw = $signed({1'b0, cfg_i.center_y}) - $signed({1'b0, q_data_i.far_y});
  assign dv_raw = $signed({1'b0, q_data_i.far_x}) - $signed({1'b0, cfg_i.center_x});
  assign du_ext = DATA_W'(du_raw) <<< SCALE_SHIFT;
  assign dv_ext = DATA_W'(dv_raw) <<< SCALE_SHIFT;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (step_q == STEP_W'(CORDIC_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_ITER;
        end
      end
      ST_ITER: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: pop_o    = !q_empty_i;
      ST_ITER: begin
      end
      ST_DONE: load_out = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // one rotation step, arithmetic shifts floor
  assign du_sh    = du_q >>> step_q;
  assign dv_sh    = dv_q >>> step_q;
  assign atan_val = $signed(atan_entry(step_q));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hold_q <= q_data_i;
      zero_q <= (du_raw == '0) && (dv_raw == '0);
      step_q <= '0;
      if (du_raw < 0) begin
        du_q <= -du_ext;
        dv_q <= -dv_ext;
        z_q  <= DATA_W'(HALF_TURN_Z);
      end else begin
        du_q <= du_ext;
        dv_q <= dv_ext;
        z_q  <= '0;
      end
    end else if (state_q == ST_ITER) begin
      step_q <= step_q + STEP_W'(1);
      if (dv_q > 0) begin
        du_q <= du_q + dv_sh;
        dv_q <= dv_q - du_sh;
        z_q  <= z_q + atan_val;
      end else begin
        du_q <= du_q - dv_sh;
        dv_q <= dv_q + du_sh;
        z_q  <= z_q - atan_val;
      end
    end
  end

  // round half up to the output fraction, wrap into one turn
  assign z_rnd = z_q + DATA_W'(ROUND_HALF);
  assign r_val = R_W'(z_rnd >>> ROUND_SHIFT);

  always_comb begin
    if (r_val < 0) begin
      ang_wrap = r_val + R_W'(FULL_ANGLE);
    end else if (r_val >= R_W'(FULL_ANGLE)) begin
      ang_wrap = r_val - R_W'(FULL_ANGLE);
    end else begin
      ang_wrap = r_val;
    end
    if (zero_q) begin
      angle = ANGLE_W'(RIGHT_ANGLE);
    end else begin
      angle = ang_wrap[ANGLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      far_x_o      <= COORD_W'(hold_q.far_x);
      far_y_o      <= COORD_W'(hold_q.far_y);
      hand_angle_o <= angle;
      found_o      <= hold_q.found;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/farthest_white_pixel_angle_core.sv
// Farthest white pixel angle core: one pixel accepted per cycle while the
// result queue has room; the back end works on one frame result at a time
// with its single iterative cordic, so a run of short frames fills the
// 4-entry queue and then paces intake. Reset is asynchronous active low:
// counters, kept point, queue and handshakes clear, registers return to
// 640/416/253/255.
`default_nettype none

module farthest_white_pixel_angle_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fwpa_pkg::PADDR_W-1:0]  paddr,
  input  logic [fwpa_pkg::PDATA_W-1:0]  pwdata,
  output logic [fwpa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fwpa_pkg::PIXEL_W-1:0]  pixel_i,
  input  logic                          end_of_frame_i,
  // frame result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fwpa_pkg::COORD_W-1:0]  far_x_o,
  output logic [fwpa_pkg::COORD_W-1:0]  far_y_o,
  output logic [fwpa_pkg::ANGLE_W-1:0]  hand_angle_o,
  output logic                          found_o
);
  import fwpa_pkg::*;

  cfg_t               cfg_q;
  reg_idx_e           reg_idx;
  logic               cfg_we;
  logic               q_push, q_pop, q_empty;
  frame_res_t         q_wdata, q_rdata;
  logic [Q_CNT_W-1:0] q_count;

  // register write and read
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= IMAGE_WIDTH_RST;
      cfg_q.center_x    <= CENTER_X_RST;
      cfg_q.center_y    <= CENTER_Y_RST;
      cfg_q.white_level <= WHITE_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[WIDTH_W-1:0];
        REG_CENTER_X:    cfg_q.center_x    <= pwdata[CENTER_W-1:0];
        REG_CENTER_Y:    cfg_q.center_y    <= pwdata[CENTER_W-1:0];
        REG_WHITE_LEVEL: cfg_q.white_level <= pwdata[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH: prdata = PDATA_W'(cfg_q.image_width);
      REG_CENTER_X:    prdata = PDATA_W'(cfg_q.center_x);
      REG_CENTER_Y:    prdata = PDATA_W'(cfg_q.center_y);
      REG_WHITE_LEVEL: prdata = PDATA_W'(cfg_q.white_level);
      default:         prdata = '0;
    endcase
  end

  // front: pixel intake and farthest point
  fwpa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .end_of_frame_i (end_of_frame_i),
    .q_count_i      (q_count),
    .push_o         (q_push),
    .push_data_o    (q_wdata)
  );

  // frame result queue
  fwpa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  // back: angle and output register
  fwpa_cordic u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .far_x_o      (far_x_o),
    .far_y_o      (far_y_o),
    .hand_angle_o (hand_angle_o),
    .found_o      (found_o)
  );

  // angle always within one turn
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hand_angle_o < ANGLE_W'(FULL_ANGLE)))
    else $error("hand angle out of range");

  // no white pixel means the origin point
  a_not_found_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (far_x_o == '0 && far_y_o == '0))
    else $error("point reported without a white pixel");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count <= Q_CNT_W'(Q_DEPTH)) && !(q_push && q_count == Q_CNT_W'(Q_DEPTH)))
    else $error("result queue overflow");

  // intake only stalls on a queue that holds results
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (q_count != '0))
    else $error("pixel intake stalled with empty queue");

endmodule

`default_nettype wire

FILE: tb/farthest_white_pixel_angle_core_tb.sv
// farthest_white_pixel_angle_core_tb: self-checking bench for the farthest white pixel core;
// pixel frames in over valid/ready, hand results checked against an in-bench predictor
// depends on fwpa_pkg and the farthest_white_pixel_angle_core rtl only

typedef struct packed {
  logic [11:0] far_x;
  logic [11:0] far_y;
  logic [14:0] hand_angle;
  logic        found;
} hand_result_t;

// predicts one hand result per frame and checks what the core delivers
class far_pixel_scoreboard;
  int image_width;
  int center_x;
  int center_y;
  int white_level;

  int     col;
  int     row;
  longint best_dist_sq;
  int     best_x;
  int     best_y;

  longint       atan_z[20];
  hand_result_t expected_hands[$];

  int errors;
  int pixels;
  int frames;
  int compared;

  function new();
    // arctangent of 2^-i, units of 2^-16 degree
    atan_z = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
               14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    image_width = 640;
    center_x    = 416;
    center_y    = 253;
    white_level = 255;
    errors      = 0;
    pixels      = 0;
    frames      = 0;
    compared    = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    col          = 0;
    row          = 0;
    best_dist_sq = 0;
    best_x       = 0;
    best_y       = 0;
  endfunction

  function void write_reg(fwpa_pkg::reg_idx_e idx, logic [31:0] value);
    case (idx)
      fwpa_pkg::REG_IMAGE_WIDTH: image_width = int'(value[12:0]);
      fwpa_pkg::REG_CENTER_X:    center_x    = int'(value[11:0]);
      fwpa_pkg::REG_CENTER_Y:    center_y    = int'(value[11:0]);
      fwpa_pkg::REG_WHITE_LEVEL: white_level = int'(value[7:0]);
      default: ;
    endcase
  endfunction

  // vectoring cordic from twelve o'clock, clockwise, 1/64 degree
  function logic [14:0] hand_angle_of(longint du, longint dv);
    longint z;
    longint r;
    longint u;
    longint full;
    int     i;
    full = 360 * 64;
    z    = 0;
    if (du == 0 && dv == 0) begin
      return 15'(90 * 64);
    end
    du = du * 1024;
    dv = dv * 1024;
    // lower half plane: turn by a half circle first
    if (du < 0) begin
      du = -du;
      dv = -dv;
      z  = 180 * 65536;
    end
    for (i = 0; i < 20; i++) begin
      u = du;
      if (dv > 0) begin
        du = u + (dv >>> i);
        dv = dv - (u >>> i);
        z  = z + atan_z[i];
      end else begin
        du = u - (dv >>> i);
        dv = dv + (u >>> i);
        z  = z - atan_z[i];
      end
    end
    r = (z + 512) >>> 10;
    while (r < 0) r = r + full;
    while (r >= full) r = r - full;
    return 15'(r);
  endfunction

  function void note_pixel(logic [7:0] pix, logic last);
    int           w;
    longint       dx;
    longint       dy;
    longint       d;
    hand_result_t res;
    w = image_width;
    if (w < 1) w = 1;
    if (w > 4096) w = 4096;
    pixels++;
    // keep only a strictly farther white pixel
    if (int'(pix) == white_level) begin
      dx = longint'(col) - longint'(center_x);
      dy = longint'(row) - longint'(center_y);
      d  = dx * dx + dy * dy;
      if (d > best_dist_sq) begin
        best_dist_sq = d;
        best_x       = col;
        best_y       = row;
      end
    end
    // raster position, row wraps at the height limit
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= 4096) ? 0 : row + 1;
    end else begin
      col++;
    end
    if (last) begin
      res.far_x      = 12'(best_x);
      res.far_y      = 12'(best_y);
      res.hand_angle = hand_angle_of(longint'(center_y - best_y), longint'(best_x - center_x));
      res.found      = (best_dist_sq != 0);
      expected_hands = {expected_hands, res};
      frames++;
      clear_frame();
    end
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(hand_result_t got);
    hand_result_t want;
    if (expected_hands.size() == 0) begin
      errors++;
      $display("%0t: result with no frame pending, far_x %0d far_y %0d angle %0d found %0d",
               $time, got.far_x, got.far_y, got.hand_angle, got.found);
      return;
    end
    want = expected_hands.pop_front();
    compared++;
    compare_field("far_x", want.far_x, got.far_x);
    compare_field("far_y", want.far_y, got.far_y);
    compare_field("hand_angle", want.hand_angle, got.hand_angle);
    compare_field("found", want.found, got.found);
  endfunction

  function int pending_count();
    return expected_hands.size();
  endfunction
endclass

module farthest_white_pixel_angle_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwpa_pkg::*;

  localparam int HOLD_OFF = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [PIXEL_W-1:0]   pixel_i;
  logic                 end_of_frame_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [COORD_W-1:0]   far_x_o;
  logic [COORD_W-1:0]   far_y_o;
  logic [ANGLE_W-1:0]   hand_angle_o;
  logic                 found_o;

  far_pixel_scoreboard sb;
  int feed_idle_pct;
  int sink_idle_pct;
  int hold_off_cycles;
  int reg_writes;

  farthest_white_pixel_angle_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .far_x_o        (far_x_o),
    .far_y_o        (far_y_o),
    .hand_angle_o   (hand_angle_o),
    .found_o        (found_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // apb write: setup then access phase
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // one pixel transaction, with an optional idle gap in front
  task automatic send_pixel(input logic [7:0] pix, input logic last);
    int gap;
    gap = ($urandom_range(99) < feed_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_i        <= pix;
    end_of_frame_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(pix, last);
  endtask

  task automatic stop_feed();
    in_valid_i <= 1'b0;
  endtask

  // frame of random gray values, white with the given odds; close marks the last pixel
  task automatic send_frame(input int count, input int white_pct, input bit close);
    int         k;
    logic [7:0] pix;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < white_pct) pix = 8'(sb.white_level);
      else pix = 8'($urandom_range(0, 255));
      send_pixel(pix, close && (k == count - 1));
    end
  endtask

  // let every frame result out, then the back end settle
  task automatic finish_phase();
    stop_feed();
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  // new register settings, with junk above each register's width
  task automatic randomize_settings(input bit write_all);
    int w;
    int cx;
    int cy;
    int wl;
    int span;
    case ($urandom_range(9))
      0:       w = 0;
      1:       w = 1;
      2:       w = 4096;
      3:       w = 8191;
      4:       w = $urandom_range(4097, 8191);
      default: w = $urandom_range(2, 24);
    endcase
    span = (w < 1) ? 1 : ((w > 30) ? 30 : w);
    case ($urandom_range(7))
      0:       cx = 0;
      1:       cx = 4095;
      2:       cx = $urandom_range(0, 4095);
      default: cx = $urandom_range(0, span + 1);
    endcase
    case ($urandom_range(7))
      0:       cy = 0;
      1:       cy = 4095;
      2:       cy = $urandom_range(0, 4095);
      default: cy = $urandom_range(0, 10);
    endcase
    case ($urandom_range(5))
      0:       wl = 0;
      1:       wl = 255;
      default: wl = $urandom_range(0, 255);
    endcase
    if (write_all || $urandom_range(3) != 0) reg_write(REG_IMAGE_WIDTH, 32'(w) | ($urandom << 13));
    if (write_all || $urandom_range(3) != 0) reg_write(REG_CENTER_X, 32'(cx) | ($urandom << 12));
    if (write_all || $urandom_range(3) != 0) reg_write(REG_CENTER_Y, 32'(cy) | ($urandom << 12));
    if (write_all || $urandom_range(3) != 0) reg_write(REG_WHITE_LEVEL, 32'(wl) | ($urandom << 8));
  endtask

  // result side: random or held-off ready, every transaction checked
  initial begin : result_sink
    int           stall_left;
    hand_result_t got;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.far_x      = far_x_o;
        got.far_y      = far_y_o;
        got.hand_angle = hand_angle_o;
        got.found      = found_o;
        sb.check_result(got);
      end
      if (hold_off_cycles > 0) begin
        stall_left      = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int k;
    int mode;
    int base;
    int target;
    int nframes;
    int f;
    int len;
    int pct;
    sb              = new();
    feed_idle_pct   = 0;
    sink_idle_pct   = 0;
    hold_off_cycles = 0;
    reg_writes      = 0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    pixel_i         = '0;
    end_of_frame_i  = 1'b0;
    out_ready_i     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: white pixel at origin, then a frame with no white
    send_pixel(8'hff, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hfe, 1'b1);
    finish_phase();

    // 3x3 frame around (1,1), white level zero: center white ignored, first of a tie kept
    reg_write(REG_IMAGE_WIDTH, 32'd3);
    reg_write(REG_CENTER_X, 32'd1);
    reg_write(REG_CENTER_Y, 32'd1);
    reg_write(REG_WHITE_LEVEL, 32'd0);
    for (k = 0; k < 9; k++) send_pixel((k == 1 || k == 4 || k == 7) ? 8'h00 : 8'hff, k == 8);
    finish_phase();

    // width zero acts as one; empty frame with center at origin, then point below
    reg_write(REG_CENTER_X, 32'd0);
    reg_write(REG_CENTER_Y, 32'd0);
    reg_write(REG_IMAGE_WIDTH, 32'd0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'haa, 1'b1);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b1);
    finish_phase();

    // oversize width clamps, so a short frame stays on the first row
    reg_write(REG_IMAGE_WIDTH, 32'd8191);
    reg_write(REG_WHITE_LEVEL, 32'd255);
    for (k = 0; k < 24; k++)
      send_pixel((k == 20) ? 8'hff : 8'($urandom_range(0, 254)), k == 23);
    finish_phase();

    // width one: every pixel opens a new row
    reg_write(REG_IMAGE_WIDTH, 32'd1);
    for (k = 0; k < 24; k++)
      send_pixel((k == 9 || k == 17) ? 8'hff : 8'($urandom_range(0, 254)), k == 23);
    finish_phase();

    // random frames under three idle mixes
    base   = sb.pixels;
    target = 0;
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin feed_idle_pct = 8;  sink_idle_pct = 60; end
        1:       begin feed_idle_pct = 60; sink_idle_pct = 8;  end
        default: begin feed_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      target = target + 150;
      randomize_settings(1'b1);
      while (sb.pixels - base < target) begin
        nframes = $urandom_range(2, 6);
        for (f = 0; f < nframes; f++) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
          case ($urandom_range(3))
            0:       pct = 0;
            1:       pct = 5;
            2:       pct = 20;
            default: pct = 60;
          endcase
          send_frame(len, pct, 1'b1);
        end
        // sometimes leave a frame open across the settings change
        if ($urandom_range(3) == 0) send_frame($urandom_range(1, 12), 20, 1'b0);
        finish_phase();
        randomize_settings(1'b0);
      end
    end
    send_frame($urandom_range(1, 5), 20, 1'b1);
    finish_phase();

    // long result stall while short frames keep coming
    feed_idle_pct = 0;
    sink_idle_pct = 0;
    reg_write(REG_IMAGE_WIDTH, 32'd3);
    hold_off_cycles = HOLD_OFF;
    repeat (16) send_frame($urandom_range(1, 4), 30, 1'b1);
    stop_feed();

    // drain and settle
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("tb: %0d pixels in %0d frames, %0d hand results compared, %0d register writes",
             sb.pixels, sb.frames, sb.compared, reg_writes);
    $display("tb: idle mixes on either side, open frames across settings, %0d-cycle output stall",
             HOLD_OFF);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/fwpa_pkg.sv
hw/rtl/fwpa_front.sv
hw/rtl/fwpa_fifo.sv
hw/rtl/fwpa_cordic.sv
hw/rtl/farthest_white_pixel_angle_core.sv
tb/farthest_white_pixel_angle_core_tb.sv
